// ----- design/nsp_pkg.sv -----
// Package for the nested scope profiler: item types, stack control structs,
// operation and status codes, and the region id reduction function.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package nsp_pkg;

    localparam int NUM_REGIONS_DEF = 64;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int ACC_WIDTH_DEF   = 48;

    localparam int OP_W     = 2;
    localparam int REGION_W = 6;
    localparam int TS_W     = 32;
    localparam int OUT_W    = 48;
    localparam int DEPTH_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
    localparam logic [OP_W-1:0] OP_EXIT  = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [REGION_W-1:0] region;
        logic [TS_W-1:0]     timestamp;
    } t_nsp_in;

    typedef struct packed {
        logic [OUT_W-1:0]    self_time;
        logic [OUT_W-1:0]    inclusive_time;
        logic [OUT_W-1:0]    total_time;
        logic [DEPTH_W-1:0]  depth;
        logic [STATUS_W-1:0] status;
    } t_nsp_out;

    typedef struct packed {
        logic                push;
        logic                pop;
        logic [REGION_W-1:0] region;
        logic [TS_W-1:0]     start;
    } t_nsp_stk_cmd;

    typedef struct packed {
        logic [REGION_W-1:0] top_region;
        logic [TS_W-1:0]     top_start;
        logic [REGION_W-1:0] n_top_region;
    } t_nsp_stk_stat;

    // Reduces a region id modulo the region count by conditional subtraction
    // of shifted copies of the count, one step per id bit.
    function automatic logic [REGION_W-1:0] reduce_region(
        input logic [REGION_W-1:0] region,
        input int                  count
    );
        logic [15:0] v;
        v = {10'd0, region};
        for (int k = REGION_W - 1; k >= 0; k--) begin
            if (v >= 16'(count << k)) begin
                v = v - 16'(count << k);
            end
        end
        return v[REGION_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/nsp_acc_table.sv -----
// Region accumulator table: one write port, two registered read ports with
// forwarding of a write that lands at the same edge as the read.
// Depends on nsp_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module nsp_acc_table #(
    parameter int  DEPTH = nsp_pkg::NUM_REGIONS_DEF,
    parameter int  AW    = nsp_pkg::ACC_WIDTH_DEF,
    localparam int RW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [RW-1:0] i_waddr,
    input  wire logic [AW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [RW-1:0] i_raddr_a,
    input  wire logic [RW-1:0] i_raddr_b,
    output logic      [AW-1:0] o_rdata_a,
    output logic      [AW-1:0] o_rdata_b
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] r_rd_a;
    logic [AW-1:0] r_rd_b;
    logic          r_byp_a;
    logic          r_byp_b;
    logic [AW-1:0] r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a     <= mem[i_raddr_a];
            r_rd_b     <= mem[i_raddr_b];
            r_byp_a    <= i_we && (i_waddr == i_raddr_a);
            r_byp_b    <= i_we && (i_waddr == i_raddr_b);
            r_byp_data <= i_wdata;
        end
    end

    assign o_rdata_a = r_byp_a ? r_byp_data : r_rd_a;
    assign o_rdata_b = r_byp_b ? r_byp_data : r_rd_b;

endmodule

`default_nettype wire

// ----- design/nsp_stack.sv -----
// Stack of open regions with their start times. The top and the entry below
// it are held in registers; deeper entries live in a memory.
// Depends on nsp_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module nsp_stack #(
    parameter int  STACK_DEPTH = nsp_pkg::STACK_DEPTH_DEF,
    localparam int CW          = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire nsp_pkg::t_nsp_stk_cmd i_cmd,
    output nsp_pkg::t_nsp_stk_stat     o_stat,
    output logic [CW-1:0]              o_count
);

    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [nsp_pkg::REGION_W-1:0] mem_region [STACK_DEPTH];
    logic [nsp_pkg::TS_W-1:0]     mem_start  [STACK_DEPTH];

    logic [CW-1:0]                r_count;
    logic [nsp_pkg::REGION_W-1:0] r_top_region;
    logic [nsp_pkg::TS_W-1:0]     r_top_start;
    logic [nsp_pkg::REGION_W-1:0] r_below_region;
    logic [nsp_pkg::TS_W-1:0]     r_below_start;
    logic [CW-1:0]                below_addr;

    assign below_addr = r_count - CW'(3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.pop) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem_region[r_count[IW-1:0]] <= i_cmd.region;
            mem_start[r_count[IW-1:0]]  <= i_cmd.start;
            r_top_region                <= i_cmd.region;
            r_top_start                 <= i_cmd.start;
            r_below_region              <= r_top_region;
            r_below_start               <= r_top_start;
        end else if (i_cmd.pop) begin
            r_top_region   <= r_below_region;
            r_top_start    <= r_below_start;
            r_below_region <= mem_region[below_addr[IW-1:0]];
            r_below_start  <= mem_start[below_addr[IW-1:0]];
        end
    end

    always_comb begin
        o_stat.top_region = r_top_region;
        o_stat.top_start  = r_top_start;
        if (i_cmd.push) begin
            o_stat.n_top_region = i_cmd.region;
        end else if (i_cmd.pop) begin
            o_stat.n_top_region = r_below_region;
        end else begin
            o_stat.n_top_region = r_top_region;
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- design/nested_scope_profiler_core.sv -----
// Nested scope profiler: an input register, one pass of update logic, and a
// result register; the region tables are read when an item is accepted.
// Each accepted item moves from the input register through the update logic into the result register.
// Throughput: one item per cycle while the output is not stalled, set by the table read-modify-write.
// Reset: synchronous; afterwards a clearing pass writes zero to each region table entry in turn
// while input items are stalled.
`timescale 1ns / 1ps
`default_nettype none

module nested_scope_profiler_core #(
    parameter int NUM_REGIONS = nsp_pkg::NUM_REGIONS_DEF,
    parameter int STACK_DEPTH = nsp_pkg::STACK_DEPTH_DEF,
    parameter int ACC_WIDTH   = nsp_pkg::ACC_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire nsp_pkg::t_nsp_in i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output nsp_pkg::t_nsp_out     o_out_data
);

    localparam int RW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = ACC_WIDTH;
    localparam int SW = AW + 1;
    localparam int OW = nsp_pkg::OUT_W;
    localparam int DW = nsp_pkg::DEPTH_W;
    localparam int TW = nsp_pkg::TS_W;

    function automatic logic [AW-1:0] sat_add(
        input logic [AW-1:0] acc,
        input logic [TW-1:0] inc
    );
        logic [SW-1:0] sum;
        sum = {1'b0, acc} + SW'(inc);
        return sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
    endfunction

    logic                         r_clr_busy;
    logic [RW-1:0]                r_clr_idx;
    logic                         r_in_valid;
    nsp_pkg::t_nsp_in             r_in;
    logic [TW-1:0]                r_last;
    logic [AW-1:0]                r_total;
    logic                         r_out_valid;
    nsp_pkg::t_nsp_out            r_out_data;

    logic                         process;
    logic                         in_accept;
    logic [nsp_pkg::REGION_W-1:0] in_idx;
    nsp_pkg::t_nsp_stk_cmd        stk_cmd;
    nsp_pkg::t_nsp_stk_stat       stk_stat;
    logic [CW-1:0]                stk_count;
    logic [CW-1:0]                n_count;
    logic                         is_enter;
    logic                         is_exit;
    logic                         stk_empty;
    logic                         stk_full;
    logic                         do_push;
    logic                         do_pop;
    logic                         charge;
    logic [TW-1:0]                delta;
    logic [TW-1:0]                span;
    logic [AW-1:0]                own_top;
    logic [AW-1:0]                own_rep;
    logic [AW-1:0]                nest_top;
    logic [AW-1:0]                nest_rep;
    logic [AW-1:0]                own_new;
    logic [AW-1:0]                nest_new;
    logic [AW-1:0]                n_total;
    logic [AW-1:0]                self_val;
    logic [AW-1:0]                incl_val;
    logic [nsp_pkg::STATUS_W-1:0] status_val;
    logic                         own_we;
    logic                         nest_we;
    logic [RW-1:0]                tbl_waddr;
    nsp_pkg::t_nsp_out            n_out_data;

    assign process    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_in_valid && !process);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_idx     = nsp_pkg::reduce_region(i_in_data.region, NUM_REGIONS);

    assign is_enter  = (r_in.op == nsp_pkg::OP_ENTER);
    assign is_exit   = (r_in.op == nsp_pkg::OP_EXIT);
    assign stk_empty = (stk_count == '0);
    assign stk_full  = (stk_count >= CW'(STACK_DEPTH));
    assign do_push   = is_enter && !stk_full;
    assign do_pop    = is_exit && !stk_empty;
    assign charge    = (do_push && !stk_empty) || do_pop;
    assign delta     = r_in.timestamp - r_last;
    assign span      = r_in.timestamp - stk_stat.top_start;
    assign own_new   = sat_add(own_top, delta);
    assign nest_new  = sat_add(nest_top, span);
    assign n_total   = charge ? sat_add(r_total, delta) : r_total;
    assign n_count   = stk_count + CW'(do_push) - CW'(do_pop);

    always_comb begin
        stk_cmd.push   = process && do_push;
        stk_cmd.pop    = process && do_pop;
        stk_cmd.region = r_in.region;
        stk_cmd.start  = r_in.timestamp;
    end

    nsp_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (stk_cmd),
        .o_stat (stk_stat),
        .o_count(stk_count)
    );

    assign own_we    = r_clr_busy || (process && charge);
    assign nest_we   = r_clr_busy || (process && do_pop);
    assign tbl_waddr = r_clr_busy ? r_clr_idx : RW'(stk_stat.top_region);

    nsp_acc_table #(
        .DEPTH(NUM_REGIONS),
        .AW   (AW)
    ) u_own_table (
        .i_clk    (i_clk),
        .i_we     (own_we),
        .i_waddr  (tbl_waddr),
        .i_wdata  (r_clr_busy ? {AW{1'b0}} : own_new),
        .i_re     (in_accept),
        .i_raddr_a(RW'(stk_stat.n_top_region)),
        .i_raddr_b(RW'(in_idx)),
        .o_rdata_a(own_top),
        .o_rdata_b(own_rep)
    );

    nsp_acc_table #(
        .DEPTH(NUM_REGIONS),
        .AW   (AW)
    ) u_nest_table (
        .i_clk    (i_clk),
        .i_we     (nest_we),
        .i_waddr  (tbl_waddr),
        .i_wdata  (r_clr_busy ? {AW{1'b0}} : nest_new),
        .i_re     (in_accept),
        .i_raddr_a(RW'(stk_stat.n_top_region)),
        .i_raddr_b(RW'(in_idx)),
        .o_rdata_a(nest_top),
        .o_rdata_b(nest_rep)
    );

    always_comb begin
        status_val = nsp_pkg::ST_OK;
        if (is_exit) begin
            if (stk_empty) begin
                status_val = nsp_pkg::ST_EMPTY;
                self_val   = '0;
                incl_val   = '0;
            end else begin
                self_val = own_new;
                incl_val = nest_new;
            end
        end else begin
            if (is_enter && stk_full) begin
                status_val = nsp_pkg::ST_FULL;
            end
            // An enter that charges the region it pushes again sees its own charge.
            if (charge && (r_in.region == stk_stat.top_region)) begin
                self_val = own_new;
            end else begin
                self_val = own_rep;
            end
            incl_val = nest_rep;
        end
        n_out_data.self_time      = OW'(self_val);
        n_out_data.inclusive_time = OW'(incl_val);
        n_out_data.total_time     = OW'(n_total);
        n_out_data.depth          = DW'(n_count);
        n_out_data.status         = status_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_total     <= '0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_idx == RW'(NUM_REGIONS - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_idx <= r_clr_idx + RW'(1);
                end
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (process) begin
                r_out_valid <= 1'b1;
                r_total     <= n_total;
                if (do_push || do_pop) begin
                    r_last <= r_in.timestamp;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.op        <= i_in_data.op;
            r_in.region    <= in_idx;
            r_in.timestamp <= i_in_data.timestamp;
        end
        if (process) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process |=> o_out_valid)
        else $error("Processed item did not produce a valid result.");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !in_accept)
        else $error("Item accepted during the table clearing pass.");

    a_held_item_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !process) |=> (r_in_valid && $stable(r_in)))
        else $error("Waiting item was lost or changed.");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && do_pop) |=> (stk_count == $past(stk_count) - CW'(1)))
        else $error("Exit did not reduce the open region count by one.");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_count <= CW'(STACK_DEPTH))
        else $error("Open region count exceeds the stack depth.");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for nested_scope_profiler_core: a table of directed events, then random
// enter/exit/read/reserved traffic, then a short run of backward clock steps with wrapped charges.
// Depends on nsp_pkg and the core; results are checked against a predictor kept here or the table's typed rows.
`timescale 1ns / 1ps

module tb;

    localparam logic [nsp_pkg::OP_W-1:0] OP_READ = 2'd2;
    localparam logic [nsp_pkg::OP_W-1:0] OP_RSVD = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_EVENTS = 1000;
    localparam int SAT_PAIRS = 6;
    localparam nsp_pkg::t_nsp_out NO_WANT = '0;

    typedef enum int { STALL_NONE, STALL_RANDOM, STALL_PERIODIC } t_stall_mode;

    typedef struct packed {
        nsp_pkg::t_nsp_in  ev;
        logic [4:0]        reps;
        logic              typed;
        nsp_pkg::t_nsp_out want;
    } t_plan_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    nsp_pkg::t_nsp_in in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    nsp_pkg::t_nsp_out out_item;

    nested_scope_profiler_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_item)
    );

    always #2 clk = ~clk;

    logic [nsp_pkg::REGION_W-1:0] frame_region [nsp_pkg::STACK_DEPTH_DEF];
    logic [nsp_pkg::TS_W-1:0]     frame_start [nsp_pkg::STACK_DEPTH_DEF];
    int                           frame_count = 0;
    logic [nsp_pkg::TS_W-1:0]     prev_stamp = '0;
    logic [nsp_pkg::OUT_W-1:0]    charged_total = '0;
    logic [nsp_pkg::OUT_W-1:0]    own_acc [nsp_pkg::NUM_REGIONS_DEF] = '{default: '0};
    logic [nsp_pkg::OUT_W-1:0]    nested_acc [nsp_pkg::NUM_REGIONS_DEF] = '{default: '0};

    nsp_pkg::t_nsp_out profile_q[$];
    t_plan_row plan[$];
    int        err_count = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;
    int        hold_orders = 0;
    logic [nsp_pkg::TS_W-1:0] now_ts = '0;

    function automatic logic [nsp_pkg::OUT_W-1:0] add_clamped(
        input logic [nsp_pkg::OUT_W-1:0] acc,
        input logic [nsp_pkg::TS_W-1:0]  inc
    );
        logic [nsp_pkg::OUT_W:0] sum;
        sum = {1'b0, acc} + {{(nsp_pkg::OUT_W - nsp_pkg::TS_W + 1){1'b0}}, inc};
        return sum[nsp_pkg::OUT_W] ? {nsp_pkg::OUT_W{1'b1}} : sum[nsp_pkg::OUT_W-1:0];
    endfunction

    function automatic void charge_top_frame(input logic [nsp_pkg::TS_W-1:0] stamp);
        logic [nsp_pkg::TS_W-1:0] elapsed;
        logic [nsp_pkg::REGION_W-1:0] top_id;
        elapsed = stamp - prev_stamp;
        top_id = frame_region[frame_count - 1];
        own_acc[top_id] = add_clamped(own_acc[top_id], elapsed);
        charged_total = add_clamped(charged_total, elapsed);
        prev_stamp = stamp;
    endfunction

    function automatic nsp_pkg::t_nsp_out profile_event(input nsp_pkg::t_nsp_in ev);
        nsp_pkg::t_nsp_out res;
        logic [nsp_pkg::REGION_W-1:0] reg_id;
        logic [nsp_pkg::TS_W-1:0] span;
        int top;
        bit have;
        res = '0;
        res.status = nsp_pkg::ST_OK;
        reg_id = ev.region;
        have = 1'b1;
        if (ev.op == nsp_pkg::OP_ENTER) begin
            if (frame_count >= nsp_pkg::STACK_DEPTH_DEF) begin
                res.status = nsp_pkg::ST_FULL;
            end else begin
                if (frame_count == 0) begin
                    prev_stamp = ev.timestamp;
                end else begin
                    charge_top_frame(ev.timestamp);
                end
                frame_region[frame_count] = reg_id;
                frame_start[frame_count] = ev.timestamp;
                frame_count++;
            end
        end else if (ev.op == nsp_pkg::OP_EXIT) begin
            if (frame_count == 0) begin
                res.status = nsp_pkg::ST_EMPTY;
                have = 1'b0;
            end else begin
                top = frame_count - 1;
                reg_id = frame_region[top];
                span = ev.timestamp - frame_start[top];
                nested_acc[reg_id] = add_clamped(nested_acc[reg_id], span);
                charge_top_frame(ev.timestamp);
                frame_count--;
            end
        end
        if (have) begin
            res.self_time = own_acc[reg_id];
            res.inclusive_time = nested_acc[reg_id];
        end
        res.total_time = charged_total;
        res.depth = 5'(frame_count);
        return res;
    endfunction

    function automatic nsp_pkg::t_nsp_in make_event(
        input logic [nsp_pkg::OP_W-1:0]     op,
        input logic [nsp_pkg::REGION_W-1:0] region,
        input logic [nsp_pkg::TS_W-1:0]     stamp
    );
        nsp_pkg::t_nsp_in ev;
        ev.op = op;
        ev.region = region;
        ev.timestamp = stamp;
        return ev;
    endfunction

    function automatic t_plan_row plan_row(input nsp_pkg::t_nsp_in ev, input int reps,
                                           input bit typed, input nsp_pkg::t_nsp_out want);
        t_plan_row row;
        row.ev = ev;
        row.reps = 5'(reps);
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    // Mostly well-formed nesting with growing timestamps; the rest is noise.
    function automatic nsp_pkg::t_nsp_in random_event();
        nsp_pkg::t_nsp_in ev;
        int pick;
        int choice;
        int step_kind;
        pick = $urandom_range(0, 99);
        choice = $urandom_range(0, 99);
        step_kind = $urandom_range(0, 9);
        ev.region = ($urandom_range(0, 1) == 0) ? nsp_pkg::REGION_W'($urandom_range(0, 7))
                                               : nsp_pkg::REGION_W'($urandom);
        if (pick < 85) begin
            if (frame_count == 0) begin
                ev.op = (choice < 90) ? nsp_pkg::OP_ENTER : nsp_pkg::OP_EXIT;
            end else if (frame_count >= nsp_pkg::STACK_DEPTH_DEF) begin
                ev.op = (choice < 80) ? nsp_pkg::OP_EXIT : nsp_pkg::OP_ENTER;
            end else if (choice < 45) begin
                ev.op = nsp_pkg::OP_ENTER;
            end else if (choice < 85) begin
                ev.op = nsp_pkg::OP_EXIT;
            end else begin
                ev.op = (choice < 95) ? OP_READ : OP_RSVD;
            end
            if (step_kind < 7) begin
                now_ts = now_ts + $urandom_range(0, 15);
            end else if (step_kind < 9) begin
                now_ts = now_ts + $urandom_range(0, 65535);
            end else begin
                now_ts = now_ts + $urandom;
            end
            ev.timestamp = now_ts;
        end else begin
            ev.op = nsp_pkg::OP_W'($urandom);
            ev.timestamp = $urandom;
            now_ts = ev.timestamp;
        end
        return ev;
    endfunction

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_item(input nsp_pkg::t_nsp_in ev, input bit typed,
                             input nsp_pkg::t_nsp_out want);
        nsp_pkg::t_nsp_out predicted;
        in_valid <= 1'b1;
        in_item <= ev;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        predicted = profile_event(ev);
        profile_q.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (profile_q.size() != 0) @(posedge clk);
    endtask

    // Receiver: checks accepted items, then picks the stall for the next cycle.
    t_stall_mode stall_mode = STALL_NONE;
    int mode_left = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_cnt = 0;

    always @(posedge clk) begin
        nsp_pkg::t_nsp_out want;
        cycle_cnt++;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (profile_q.size() == 0) begin
                    if (err_count < 10) begin
                        $display(
                            "unexpected result item: self=%h incl=%h total=%h depth=%0d status=%0d",
                            out_item.self_time, out_item.inclusive_time,
                            out_item.total_time, out_item.depth, out_item.status);
                    end
                    err_count++;
                end else begin
                    want = profile_q.pop_front();
                    if (out_item.self_time !== want.self_time
                            || out_item.inclusive_time !== want.inclusive_time
                            || out_item.total_time !== want.total_time
                            || out_item.depth !== want.depth
                            || out_item.status !== want.status) begin
                        if (err_count < 10) begin
                            $display(
                                "mismatch: expected self=%h incl=%h total=%h depth=%0d status=%0d",
                                want.self_time, want.inclusive_time, want.total_time,
                                want.depth, want.status);
                            $display(
                                "          actual   self=%h incl=%h total=%h depth=%0d status=%0d",
                                out_item.self_time, out_item.inclusive_time,
                                out_item.total_time, out_item.depth, out_item.status);
                        end
                        err_count++;
                    end
                end
            end
            if (hold_orders != hold_served) begin
                hold_served = hold_orders;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(32, 256);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    STALL_NONE: begin
                        out_stall <= 1'b0;
                    end
                    STALL_RANDOM: begin
                        out_stall <= ($urandom_range(0, 2) == 0);
                    end
                    default: begin
                        out_stall <= (cycle_cnt % 7 >= 4);
                    end
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        nsp_pkg::t_nsp_in ev;
        logic [nsp_pkg::TS_W-1:0] stamp;
        int n;

        plan.push_back(plan_row(make_event(OP_READ, 6'd0, 32'h0), 1, 1'b1,
                nsp_pkg::t_nsp_out'{48'd0, 48'd0, 48'd0, 5'd0, nsp_pkg::ST_OK}));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_EXIT, 6'd0, 32'hFFFF_FFFF), 1, 1'b1,
                nsp_pkg::t_nsp_out'{48'd0, 48'd0, 48'd0, 5'd0, nsp_pkg::ST_EMPTY}));
        plan.push_back(plan_row(make_event(OP_RSVD, 6'd63, 32'h1234_5678), 1, 1'b1,
                nsp_pkg::t_nsp_out'{48'd0, 48'd0, 48'd0, 5'd0, nsp_pkg::ST_OK}));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_ENTER, 6'd63, 32'hFFFF_FFF0), 1, 1'b1,
                nsp_pkg::t_nsp_out'{48'd0, 48'd0, 48'd0, 5'd1, nsp_pkg::ST_OK}));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_ENTER, 6'd0, 32'h0000_0010), 1, 1'b1,
                nsp_pkg::t_nsp_out'{48'd0, 48'd0, 48'h20, 5'd2, nsp_pkg::ST_OK}));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_EXIT, 6'd0, 32'h30),
                1, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_EXIT, 6'd0, 32'h40),
                1, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_ENTER, 6'd1, 32'h100),
                16, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_ENTER, 6'd42, 32'h200), 1, 1'b1,
                nsp_pkg::t_nsp_out'{48'd0, 48'd0, 48'h5F, 5'd16, nsp_pkg::ST_FULL}));
        plan.push_back(plan_row(make_event(OP_READ, 6'd1, 32'h0),
                1, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_EXIT, 6'd0, 32'h300),
                16, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_EXIT, 6'd0, 32'h0),
                1, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_ENTER, 6'd63, 32'hFFFF_FFFF),
                1, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_ENTER, 6'd0, 32'h0),
                1, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_ENTER, 6'd0, 32'h0),
                1, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_EXIT, 6'd63, 32'hFFFF_FFFF),
                1, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_EXIT, 6'd0, 32'hFFFF_FFFF),
                1, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(nsp_pkg::OP_EXIT, 6'd0, 32'h7FFF_FFFF),
                1, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(OP_READ, 6'd63, 32'hFFFF_FFFF),
                1, 1'b0, NO_WANT));
        plan.push_back(plan_row(make_event(OP_RSVD, 6'd0, 32'h0),
                1, 1'b0, NO_WANT));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            for (n = 0; n < plan[i].reps; n++) begin
                ev = plan[i].ev;
                ev.region = ev.region + nsp_pkg::REGION_W'(n);
                ev.timestamp = ev.timestamp + n;
                pace();
                send_item(ev, plan[i].typed, plan[i].want);
            end
        end
        wait_drained();

        now_ts = $urandom;
        for (n = 0; n < RANDOM_EVENTS; n++) begin
            if (n % 300 == 150) begin
                hold_orders <= hold_orders + 1;
                burst_left = 60;
            end
            if (n % 200 == 199) begin
                wait_drained();
            end
            pace();
            send_item(random_event(), 1'b0, NO_WANT);
        end

        // Each pair step moves the clock back by one tick, so its charges wrap to a
        // full 2^32 - 1 and the region tables climb in large steps; the exit of region 5 steps back by seven.
        while (frame_count > 0) begin
            pace();
            send_item(make_event(nsp_pkg::OP_EXIT, nsp_pkg::REGION_W'($urandom), now_ts),
                      1'b0, NO_WANT);
        end
        stamp = $urandom;
        pace();
        send_item(make_event(nsp_pkg::OP_ENTER, 6'd5, stamp), 1'b0, NO_WANT);
        for (n = 0; n < SAT_PAIRS; n++) begin
            stamp = stamp - 1;
            pace();
            send_item(make_event(nsp_pkg::OP_ENTER, 6'd6, stamp), 1'b0, NO_WANT);
            stamp = stamp - 1;
            pace();
            send_item(make_event(nsp_pkg::OP_EXIT, 6'd6, stamp), 1'b0, NO_WANT);
        end
        pace();
        send_item(make_event(OP_READ, 6'd5, stamp), 1'b0, NO_WANT);
        pace();
        send_item(make_event(nsp_pkg::OP_EXIT, 6'd5, stamp - 32'd7), 1'b0, NO_WANT);
        pace();
        send_item(make_event(OP_RSVD, 6'd6, stamp), 1'b0, NO_WANT);
        pace();
        send_item(make_event(nsp_pkg::OP_EXIT, 6'd6, stamp), 1'b0, NO_WANT);

        wait_drained();
        repeat (10) @(posedge clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
